/* rtl/tun_pkg.sv */
package tun_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int OUT_FRAC_BITS = 30;
  localparam int NUM_AXES      = 3;

endpackage

/* rtl/tun_if.sv */
interface tun_in_if import tun_pkg::*; #(
  parameter int CW = COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;
  logic signed [CW-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_out_if import tun_pkg::*; #(
  parameter int UW = OUT_FRAC_BITS + 2
);
  logic                 valid;
  logic                 ready;
  logic signed [UW-1:0] unit_x;
  logic signed [UW-1:0] unit_y;
  logic signed [UW-1:0] unit_z;
  logic                 degenerate;

  modport source (output valid, unit_x, unit_y, unit_z, degenerate, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, degenerate, output ready);
endinterface

/* rtl/tun_sqrt_cell.sv */
module tun_sqrt_cell import tun_pkg::*; #(
  parameter int SW = 134,
  parameter int RW = 67,
  parameter int PW = 201
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [SW-1:0] rad_i,
  input  logic [RW:0]   rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [SW-1:0] rad_o,
  output logic [RW:0]   rem_o,
  output logic [RW-1:0] root_o,
  output logic [PW-1:0] pay_o
);

  logic [RW+2:0] cur;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  assign cur   = {rem_i, rad_i[SW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[SW-3:0], 2'b00};
      rem_o  <= ge ? diff[RW:0] : cur[RW:0];
      root_o <= {root_i[RW-2:0], ge};
      pay_o  <= pay_i;
    end
  end

endmodule

/* rtl/tun_div_cell.sv */
module tun_div_cell import tun_pkg::*; #(
  parameter int LW = 67,
  parameter int QW = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [LW-1:0]                len_i,
  input  logic [NUM_AXES-1:0][LW-1:0]  rem_i,
  input  logic [NUM_AXES-1:0]          nbit_i,
  input  logic [NUM_AXES-1:0][QW-1:0]  q_i,
  input  logic [NUM_AXES-1:0]          sgn_i,
  input  logic                         dgn_i,
  output logic                         vld_o,
  output logic [LW-1:0]                len_o,
  output logic [NUM_AXES-1:0][LW-1:0]  rem_o,
  output logic [NUM_AXES-1:0]          nbit_o,
  output logic [NUM_AXES-1:0][QW-1:0]  q_o,
  output logic [NUM_AXES-1:0]          sgn_o,
  output logic                         dgn_o
);

  logic [NUM_AXES-1:0][LW:0] cur;
  logic [NUM_AXES-1:0][LW:0] diff;
  logic [NUM_AXES-1:0]       ge;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cur[i]  = {rem_i[i], nbit_i[i]};
      diff[i] = cur[i] - {1'b0, len_i};
      ge[i]   = (cur[i] >= {1'b0, len_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        rem_o[i] <= ge[i] ? diff[i][LW-1:0] : cur[i][LW-1:0];
        q_o[i]   <= {q_i[i][QW-2:0], ge[i]};
      end
      nbit_o <= '0;
      len_o  <= len_i;
      sgn_o  <= sgn_i;
      dgn_o  <= dgn_i;
    end
  end

endmodule

/* rtl/triangle_unit_normal.sv */
// Unit face normal of a triangle: edges a-b and b-c, exact cross product, floor
// length by digit-by-digit square root, then each component scaled by
// 2^OUT_FRAC_BITS and divided by the length (truncated) in Q2.OUT_FRAC_BITS.
// A zero length gives zero components and degenerate set. Fully pipelined: one
// item per cycle with the skid empty. 6 arithmetic stages, 2*COORD_WIDTH+3
// square root cells (two radicand bits each), OUT_FRAC_BITS+1 divider cells
// (one quotient bit each, three lanes) and the output register in turn. A skid
// register behind the output keeps input ready high while one result waits.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int CW = COORD_WIDTH,
  parameter int FB = OUT_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tun_in_if.sink    in_i,
  tun_out_if.source out_o
);

  localparam int EW  = CW + 1;
  localparam int PRW = 2 * EW;
  localparam int NW  = PRW + 1;
  localparam int MW  = NW - 1;
  localparam int HW  = MW / 2;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = SW / 2;
  localparam int PW  = NUM_AXES * (MW + 1);
  localparam int QW  = FB + 1;
  localparam int UW  = FB + 2;

  logic en;
  logic ov_q, sv_q;

  assign en       = !sv_q;
  assign in_i.ready = en;

  // stage A: edges
  logic                 va_q;
  logic signed [EW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  // stage B: products
  logic                  vb_q;
  logic signed [PRW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  // stage C: cross product
  logic                 vc_q;
  logic signed [NW-1:0] n_q [NUM_AXES];
  // stage D: split squares
  logic                      vd_q;
  logic [NUM_AXES-1:0][2*HW-1:0] hh_q, hl_q, ll_q;
  logic [NUM_AXES-1:0][MW-1:0]   magd_q;
  logic [NUM_AXES-1:0]           sgnd_q;
  // stage E: squares
  logic                        ve_q;
  logic [NUM_AXES-1:0][SW-1:0] sq_q;
  logic [NUM_AXES-1:0][MW-1:0] mage_q;
  logic [NUM_AXES-1:0]         sgne_q;
  // stage F: sum
  logic          vf_q;
  logic [SW-1:0] sum_q;
  logic [PW-1:0] payf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  logic [NUM_AXES-1:0][NW-1:0] nabs;
  logic [NUM_AXES-1:0][SW-1:0] sqc;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      nabs[i] = n_q[i][NW-1] ? NW'(-n_q[i]) : NW'(n_q[i]);
      sqc[i]  = (SW'(hh_q[i]) << (2 * HW)) + (SW'(hl_q[i]) << (HW + 1)) + SW'(ll_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1x_q <= EW'(in_i.a_x) - EW'(in_i.b_x);
      e1y_q <= EW'(in_i.a_y) - EW'(in_i.b_y);
      e1z_q <= EW'(in_i.a_z) - EW'(in_i.b_z);
      e2x_q <= EW'(in_i.b_x) - EW'(in_i.c_x);
      e2y_q <= EW'(in_i.b_y) - EW'(in_i.c_y);
      e2z_q <= EW'(in_i.b_z) - EW'(in_i.c_z);

      p0_q <= PRW'(e1y_q) * PRW'(e2z_q);
      p1_q <= PRW'(e1z_q) * PRW'(e2y_q);
      p2_q <= PRW'(e1z_q) * PRW'(e2x_q);
      p3_q <= PRW'(e1x_q) * PRW'(e2z_q);
      p4_q <= PRW'(e1x_q) * PRW'(e2y_q);
      p5_q <= PRW'(e1y_q) * PRW'(e2x_q);

      n_q[0] <= NW'(p0_q) - NW'(p1_q);
      n_q[1] <= NW'(p2_q) - NW'(p3_q);
      n_q[2] <= NW'(p4_q) - NW'(p5_q);

      for (int i = 0; i < NUM_AXES; i++) begin
        hh_q[i]   <= nabs[i][MW-1:HW] * nabs[i][MW-1:HW];
        hl_q[i]   <= nabs[i][MW-1:HW] * nabs[i][HW-1:0];
        ll_q[i]   <= nabs[i][HW-1:0] * nabs[i][HW-1:0];
        magd_q[i] <= nabs[i][MW-1:0];
        sgnd_q[i] <= n_q[i][NW-1];
      end

      sq_q   <= sqc;
      mage_q <= magd_q;
      sgne_q <= sgnd_q;

      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      payf_q <= {sgne_q, mage_q};
    end
  end

  // square root chain
  logic [RW:0]          sv;
  logic [RW:0][SW-1:0]  srad;
  logic [RW:0][RW:0]    srem;
  logic [RW:0][RW-1:0]  sroot;
  logic [RW:0][PW-1:0]  spay;

  assign sv[0]    = vf_q;
  assign srad[0]  = sum_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spay[0]  = payf_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    tun_sqrt_cell #(.SW(SW), .RW(RW), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sv[k]),
      .rad_i  (srad[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .pay_i  (spay[k]),
      .vld_o  (sv[k+1]),
      .rad_o  (srad[k+1]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1]),
      .pay_o  (spay[k+1])
    );
  end

  // divider chain
  logic [QW:0]                        dv;
  logic [QW:0][RW-1:0]                dlen;
  logic [QW:0][NUM_AXES-1:0][RW-1:0]  drem;
  logic [QW:0][NUM_AXES-1:0]          dnb;
  logic [QW:0][NUM_AXES-1:0][QW-1:0]  dq;
  logic [QW:0][NUM_AXES-1:0]          dsg;
  logic [QW:0]                        ddg;

  logic [NUM_AXES-1:0][MW-1:0] smag;
  logic [NUM_AXES-1:0]         ssgn;

  assign {ssgn, smag} = spay[RW];
  assign dv[0]   = sv[RW];
  assign dlen[0] = sroot[RW];
  assign dsg[0]  = ssgn;
  assign ddg[0]  = (sroot[RW] == '0);
  assign dq[0]   = '0;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_dinit
    assign drem[0][i] = RW'(smag[i] >> 1);
    assign dnb[0][i]  = smag[i][0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    tun_div_cell #(.LW(RW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv[k]),
      .len_i  (dlen[k]),
      .rem_i  (drem[k]),
      .nbit_i (dnb[k]),
      .q_i    (dq[k]),
      .sgn_i  (dsg[k]),
      .dgn_i  (ddg[k]),
      .vld_o  (dv[k+1]),
      .len_o  (dlen[k+1]),
      .rem_o  (drem[k+1]),
      .nbit_o (dnb[k+1]),
      .q_o    (dq[k+1]),
      .sgn_o  (dsg[k+1]),
      .dgn_o  (ddg[k+1])
    );
  end

  // result and output / skid registers
  logic [NUM_AXES-1:0][UW-1:0] res;
  logic [NUM_AXES-1:0][UW-1:0] o_q, s_q;
  logic                        od_q, sd_q;
  logic                        pv;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (ddg[QW]) begin
        res[i] = '0;
      end else if (dsg[QW][i]) begin
        res[i] = UW'(-{1'b0, dq[QW][i]});
      end else begin
        res[i] = UW'({1'b0, dq[QW][i]});
      end
    end
  end

  assign pv = dv[QW] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!ov_q || out_o.ready) begin
        ov_q <= sv_q || pv;
        sv_q <= 1'b0;
      end else if (pv) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_o.ready) begin
      if (sv_q) begin
        o_q  <= s_q;
        od_q <= sd_q;
      end else begin
        o_q  <= res;
        od_q <= ddg[QW];
      end
    end else if (pv) begin
      s_q  <= res;
      sd_q <= ddg[QW];
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.unit_x     = o_q[0];
  assign out_o.unit_y     = o_q[1];
  assign out_o.unit_z     = o_q[2];
  assign out_o.degenerate = od_q;

  a_dgn_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && od_q) |-> (o_q == '0))
    else $error("degenerate result with nonzero component");

  a_unit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !od_q) |-> (o_q != '0))
    else $error("regular result with all components zero");

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid holds an item while output is empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready && !sv_q && dv[QW]) |=> sv_q)
    else $error("stalled result not caught by skid");

endmodule

/* dv/tun_checker.sv */
module tun_checker import tun_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tun_in_if    in_i,
  tun_out_if   out_i,
  output int   fails_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UW = OUT_FRAC_BITS + 2;
  localparam int EW = COORD_WIDTH + 1;
  localparam int NW = 2 * EW + 2;
  localparam int SW = 2 * NW + 4;
  localparam int RW = SW / 2;

  typedef struct packed {
    logic signed [UW-1:0] ux;
    logic signed [UW-1:0] uy;
    logic signed [UW-1:0] uz;
    logic                 degen;
  } normal_t;

  normal_t normals_due[$];
  int      fails;
  int      due_n;

  assign fails_o   = fails;
  assign pending_o = due_n;

  function automatic logic [UW-1:0] scale_axis(logic signed [NW-1:0] n, logic [SW-1:0] len);
    logic [SW-1:0] mag;
    logic [SW-1:0] q;
    mag = (n < 0) ? SW'(-n) : SW'(n);
    q = (mag << OUT_FRAC_BITS) / len;
    if (n < 0) q = -q;
    return q[UW-1:0];
  endfunction

  function automatic normal_t face_normal(logic signed [COORD_WIDTH-1:0] v[9]);
    logic signed [NW-1:0] e1[3];
    logic signed [NW-1:0] e2[3];
    logic signed [NW-1:0] n[3];
    logic [SW-1:0] m;
    logic [SW-1:0] sum;
    logic [SW-1:0] root;
    logic [SW-1:0] cand;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = NW'(v[i]) - NW'(v[3+i]);
      e2[i] = NW'(v[3+i]) - NW'(v[6+i]);
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m = (n[i] < 0) ? SW'(-n[i]) : SW'(n[i]);
      sum = sum + m * m;
    end
    root = '0;
    for (int k = RW - 1; k >= 0; k--) begin
      cand = root | (SW'(1) << k);
      if (cand * cand <= sum) root = cand;
    end
    if (root == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, degen: 1'b1};
    end else begin
      r.ux = scale_axis(n[0], root);
      r.uy = scale_axis(n[1], root);
      r.uz = scale_axis(n[2], root);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what, logic [UW-1:0] got, logic [UW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [COORD_WIDTH-1:0] v[9];
    normal_t want;
    if (!rst_ni) begin
      fails = 0;
      due_n = 0;
      normals_due.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        v = '{in_i.a_x, in_i.a_y, in_i.a_z, in_i.b_x, in_i.b_y, in_i.b_z,
              in_i.c_x, in_i.c_y, in_i.c_z};
        normals_due = {normals_due, face_normal(v)};
      end
      if (out_i.valid && out_i.ready) begin
        if (normals_due.size() == 0) begin
          report("unexpected item", out_i.unit_x, '0);
        end else begin
          want = normals_due.pop_front();
          if (out_i.unit_x !== want.ux) report("unit_x", out_i.unit_x, want.ux);
          if (out_i.unit_y !== want.uy) report("unit_y", out_i.unit_y, want.uy);
          if (out_i.unit_z !== want.uz) report("unit_z", out_i.unit_z, want.uz);
          if (out_i.degenerate !== want.degen)
            report("degenerate", UW'(out_i.degenerate), UW'(want.degen));
        end
      end
      due_n = normals_due.size();
    end
  end
endmodule

/* dv/testbench.sv */
module testbench import tun_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = COORD_WIDTH;
  localparam int N_RANDOM  = 1500;
  localparam int IDLE_MAX  = 3000;
  localparam int HOLD_LONG = 400;
  localparam int DRAIN     = 300;

  logic clk_i;
  logic rst_ni;
  int   fails;
  int   pending;
  int   idle_cycles;
  bit   hold_req;
  bit   no_gaps;

  tun_in_if  in_ch ();
  tun_out_if out_ch ();

  triangle_unit_normal dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tun_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_ch),
    .out_i    (out_ch),
    .fails_o  (fails),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int wait_n;
    bit held_done;
    held_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_LONG) @(negedge clk_i);
        held_done = 1'b1;
      end
      wait_n = no_gaps ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        out_ch.ready = 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_tri(logic signed [CW-1:0] v[9]);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid = 1'b1;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z} = {v[0], v[1], v[2]};
    {in_ch.b_x, in_ch.b_y, in_ch.b_z} = {v[3], v[4], v[5]};
    {in_ch.c_x, in_ch.c_y, in_ch.c_z} = {v[6], v[7], v[8]};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] pick_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 8191)) - 4096;
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(CW-1){1'b0}}};
          1: return {1'b0, {(CW-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic void make_tri(output logic signed [CW-1:0] v[9]);
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      v[i] = pick_coord(kind < 4 ? 0 : (kind < 7 ? 1 : 2));
    case (kind)
      3: for (int i = 0; i < 3; i++) begin
        v[3+i] = v[i];
        v[6+i] = v[i];
      end
      6: begin
        k = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) v[6+i] = v[3+i] + k * (v[3+i] - v[i]);
      end
      5: begin
        v[5] = v[2];
        v[8] = v[2];
      end
      default: ;
    endcase
  endfunction

  initial begin
    logic signed [CW-1:0] v[9];
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    hold_req = 1'b0;
    no_gaps = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    {in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_tri(v);
    v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};         send_tri(v);
    v = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};         send_tri(v);
    v = '{mx, 0, 0, mn, 0, 0, mx, 0, 0};               send_tri(v);
    v = '{mx, mn, 0, mn, mx, 0, mx, mx, 0};            send_tri(v);
    v = '{mx, mn, mx, mn, mx, mn, mn, mn, mx};         send_tri(v);
    v = '{mn, mx, mn, mx, mn, mx, mx, mn, mn};         send_tri(v);
    v = '{mx, 0, 0, mn, mx, 0, 0, mn, mx};             send_tri(v);
    v = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0};          send_tri(v);
    v = '{0, 0, 0, 0, 65536, 0, 0, 0, 65536};          send_tri(v);
    v = '{0, 0, 0, 0, 0, 65536, 65536, 0, 0};          send_tri(v);
    v = '{0, 0, 0, 0, 0, 0, 1, 0, 0};                  send_tri(v);
    v = '{1, 2, 3, 2, 4, 6, 3, 6, 9};                  send_tri(v);
    v = '{mn, mn, mn, 0, 0, 0, mx, mx, mx};            send_tri(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                  send_tri(v);
    v = '{0, 0, 0, 1, 1, 0, 0, 1, 0};                  send_tri(v);
    v = '{-1, -1, -1, 5, -7, 3, 3, 5, -7};             send_tri(v);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) no_gaps = 1'b1;
      if (n == 420) no_gaps = 1'b0;
      if (n == 600) begin
        hold_req = 1'b1;
        no_gaps = 1'b1;
      end
      if (n == 900) no_gaps = 1'b0;
      if (n == 1100) begin
        @(negedge clk_i);
        in_ch.valid = 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      make_tri(v);
      send_tri(v);
    end
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
